// ===== rtl/mlcd_fmt_pkg.sv =====
// Shared types and codes for the memory LCD SPI frame formatter.
`timescale 1ns / 1ps

package mlcd_fmt_pkg;

    // Operation codes carried on the input tuser.
    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_REFRESH = 3'd1,
        OP_HEADER  = 3'd2,
        OP_DATA    = 3'd3,
        OP_FINISH  = 3'd4
    } t_op;

    // Configuration register indexes.
    localparam logic [1:0] REG_VCOM_MASK  = 2'd0;
    localparam logic [1:0] REG_CLEAR_MASK = 2'd1;
    localparam logic [1:0] REG_WRITE_MASK = 2'd2;
    localparam logic [1:0] REG_LINE_BYTES = 2'd3;

    localparam logic [7:0] RST_VCOM_MASK  = 8'h40;
    localparam logic [7:0] RST_CLEAR_MASK = 8'h20;
    localparam logic [7:0] RST_WRITE_MASK = 8'h80;
    localparam logic [7:0] RST_LINE_BYTES = 8'd16;

    typedef struct packed {
        logic [7:0] vcom_mask;
        logic [7:0] clear_mask;
        logic [7:0] write_mask;
        logic [7:0] line_bytes;
    } t_cfg;

    typedef struct packed {
        logic       vcom_phase;
        logic       updating;
        logic       line_open;
        logic [7:0] bytes_in_line;
    } t_state;

    // One result item.
    typedef struct packed {
        logic [7:0] spi_byte;
        logic       frame_end;
        logic       run_last;
        logic       error;
    } t_res;

    // Decoder output: one or two results plus the next state.
    typedef struct packed {
        logic   two;
        t_res   res0;
        t_res   res1;
        t_state nxt;
    } t_dec;

endpackage

// ===== rtl/mlcd_fmt_decode.sv =====
// Combinational decode of one item into its SPI bytes and next state.
`timescale 1ns / 1ps

module mlcd_fmt_decode (
    input  logic [2:0]          i_op,
    input  logic [7:0]          i_line_number,
    input  logic [7:0]          i_pixel_byte,
    input  mlcd_fmt_pkg::t_cfg   i_cfg,
    input  mlcd_fmt_pkg::t_state i_state,
    output mlcd_fmt_pkg::t_dec   o_dec
);

    // Bit reversal: line LSB goes out first on an MSB-first shifter.
    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        r = ((v & 8'haa) >> 1) | ((v & 8'h55) << 1);
        r = ((r & 8'hcc) >> 2) | ((r & 8'h33) << 2);
        r = ((r & 8'hf0) >> 4) | ((r & 8'h0f) << 4);
        return r;
    endfunction

    logic       vc_new;
    logic [7:0] vc;

    assign vc_new = ~i_state.vcom_phase;
    assign vc     = vc_new ? i_cfg.vcom_mask : 8'h00;

    always_comb begin
        o_dec      = '0;
        o_dec.nxt  = i_state;
        // default: single rejected result
        o_dec.res0 = '{spi_byte: 8'h00, frame_end: 1'b0, run_last: 1'b1, error: 1'b1};
        case (i_op)
            mlcd_fmt_pkg::OP_CLEAR, mlcd_fmt_pkg::OP_REFRESH: begin
                if (!i_state.updating) begin
                    o_dec.two            = 1'b1;
                    o_dec.nxt.vcom_phase = vc_new;
                    o_dec.res0.spi_byte  = vc | ((i_op == mlcd_fmt_pkg::OP_CLEAR) ?
                                                 i_cfg.clear_mask : 8'h00);
                    o_dec.res0.run_last  = 1'b0;
                    o_dec.res0.error     = 1'b0;
                    o_dec.res1 = '{spi_byte: 8'h00, frame_end: 1'b1, run_last: 1'b1,
                                   error: 1'b0};
                end
            end
            mlcd_fmt_pkg::OP_HEADER: begin
                if (i_line_number != 8'h00) begin
                    o_dec.two = 1'b1;
                    if (!i_state.updating) begin
                        o_dec.nxt.vcom_phase = vc_new;
                        o_dec.nxt.updating   = 1'b1;
                        o_dec.res0.spi_byte  = vc | i_cfg.write_mask;
                    end else begin
                        o_dec.res0.spi_byte  = 8'h00;
                    end
                    o_dec.nxt.line_open     = 1'b1;
                    o_dec.nxt.bytes_in_line = 8'h00;
                    o_dec.res0.run_last     = 1'b0;
                    o_dec.res0.error        = 1'b0;
                    o_dec.res1 = '{spi_byte: flip8(i_line_number), frame_end: 1'b0,
                                   run_last: 1'b1, error: 1'b0};
                end
            end
            mlcd_fmt_pkg::OP_DATA: begin
                if (i_state.updating && i_state.line_open &&
                    (i_state.bytes_in_line < i_cfg.line_bytes)) begin
                    o_dec.nxt.bytes_in_line = i_state.bytes_in_line + 8'd1;
                    o_dec.res0.spi_byte     = i_pixel_byte;
                    o_dec.res0.error        = 1'b0;
                end
            end
            mlcd_fmt_pkg::OP_FINISH: begin
                if (i_state.updating) begin
                    o_dec.two               = 1'b1;
                    o_dec.nxt.updating      = 1'b0;
                    o_dec.nxt.line_open     = 1'b0;
                    o_dec.nxt.bytes_in_line = 8'h00;
                    o_dec.res0.run_last     = 1'b0;
                    o_dec.res0.error        = 1'b0;
                    o_dec.res1 = '{spi_byte: 8'h00, frame_end: 1'b1, run_last: 1'b1,
                                   error: 1'b0};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/memory_lcd_spi_frame_formatter_core.sv =====
// Top level of the memory LCD SPI frame formatter.
`timescale 1ns / 1ps
//
// Turns display operations (clear, refresh, line header, data byte, finish)
// into the byte stream for a memory LCD, with a chip-select end mark.
// Input channel s_axis: tuser = op, tdata = line_number, pixel_byte.
// Output channel m_axis: tdata = spi_byte, tlast = frame_end,
// tuser = run_last, error. An error item carries spi_byte 0 and is not sent.
// Config port: write i_cfg_data to register i_cfg_idx when i_cfg_we is high;
// only while the block is idle.
// An accepted item is held in the input register and decoded from there;
// its results enter the result queue, whose head drives m_axis.
// Throughput: while m_axis_tready is high, the output port moves one byte per
// cycle, so data bytes and rejected items run at one item per cycle; a
// two-byte item (command, header, finish) moves on only when the queue will
// be empty after the pop. A two-entry result queue behind the decoder sets these rates.
// Reset (synchronous, active low) restores the register defaults, clears
// the VCOM phase and update state, and empties both stages.
// When the receiver stalls, the queue fills and s_axis_tready drops once
// the input register holds an item that will not fit.
//

module memory_lcd_spi_frame_formatter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] line_number, [15:8] pixel_byte
    input  logic [2:0]  s_axis_tuser,   // [2:0] op
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] spi_byte
    output logic        m_axis_tlast,   // frame_end
    output logic [1:0]  m_axis_tuser,   // [0] run_last, [1] error
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    // Configuration registers
    mlcd_fmt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vcom_mask  <= mlcd_fmt_pkg::RST_VCOM_MASK;
            r_cfg.clear_mask <= mlcd_fmt_pkg::RST_CLEAR_MASK;
            r_cfg.write_mask <= mlcd_fmt_pkg::RST_WRITE_MASK;
            r_cfg.line_bytes <= mlcd_fmt_pkg::RST_LINE_BYTES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mlcd_fmt_pkg::REG_VCOM_MASK:  r_cfg.vcom_mask  <= i_cfg_data;
                mlcd_fmt_pkg::REG_CLEAR_MASK: r_cfg.clear_mask <= i_cfg_data;
                mlcd_fmt_pkg::REG_WRITE_MASK: r_cfg.write_mask <= i_cfg_data;
                mlcd_fmt_pkg::REG_LINE_BYTES: r_cfg.line_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    logic       r_in_valid;
    logic [2:0] r_op;
    logic [7:0] r_line;
    logic [7:0] r_pix;

    // Protocol state, updated when an item leaves the input register
    mlcd_fmt_pkg::t_state r_st;
    mlcd_fmt_pkg::t_dec   dec;

    // Two-entry result queue, head at index 0
    mlcd_fmt_pkg::t_res r_q [2];
    mlcd_fmt_pkg::t_res n_q [2];
    logic [1:0]         r_cnt;
    logic [1:0]         n_cnt;
    logic [1:0]         cnt_after;
    logic               pop;
    logic               move;
    logic               in_fire;

    mlcd_fmt_decode u_dec (
        .i_op          (r_op),
        .i_line_number (r_line),
        .i_pixel_byte  (r_pix),
        .i_cfg         (r_cfg),
        .i_state       (r_st),
        .o_dec         (dec)
    );

    assign pop       = m_axis_tvalid && m_axis_tready;
    assign cnt_after = r_cnt - {1'b0, pop};
    // two results need an empty queue, one needs a free slot
    assign move      = r_in_valid && (dec.two ? (cnt_after == 2'd0) : (cnt_after != 2'd2));
    assign s_axis_tready = !r_in_valid || move;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        for (int k = 0; k < 2; k++) begin
            if (move && (cnt_after == k[1:0])) begin
                n_q[k] = dec.res0;
            end else if (move && dec.two && (cnt_after + 2'd1 == k[1:0])) begin
                n_q[k] = dec.res1;
            end
        end
        n_cnt = cnt_after + (move ? (dec.two ? 2'd2 : 2'd1) : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
            r_st       <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            r_cnt <= n_cnt;
            if (move) begin
                r_st <= dec.nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= s_axis_tuser;
            r_line <= s_axis_tdata[7:0];
            r_pix  <= s_axis_tdata[15:8];
        end
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q[0].spi_byte;
    assign m_axis_tlast  = r_q[0].frame_end;
    assign m_axis_tuser  = {r_q[0].error, r_q[0].run_last};

endmodule

// ===== rtl/mlcd_fmt_chk.sv =====
// Port-level checks for the memory LCD SPI frame formatter.
`timescale 1ns / 1ps

module mlcd_fmt_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a rejected item gives one empty result
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tuser[0] && !m_axis_tlast && (m_axis_tdata == 8'h00))
        else $error("malformed error result");

    // frame end is always the last byte of its item
    a_fend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] && (m_axis_tdata == 8'h00))
        else $error("frame end not on closing zero byte");

    // a byte that is not last of its item is always followed by the second byte
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser[0] |=>
            m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1])
        else $error("second byte of pair missing");

endmodule

bind memory_lcd_spi_frame_formatter_core mlcd_fmt_chk u_mlcd_fmt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/mlcd_stream_checker.sv =====
// Checker for the memory LCD frame formatter: predicts SPI bytes and compares results.
`timescale 1ns / 1ps

module mlcd_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,    // [7:0] line_number, [15:8] pixel_byte
    input  logic [2:0]  i_s_tuser,    // [2:0] op
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,    // [7:0] spi_byte
    input  logic        i_m_tlast,
    input  logic [1:0]  i_m_tuser,    // [0] run_last, [1] error
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output int unsigned o_fails,
    output int unsigned o_pending,
    output int unsigned o_checked
);

    mlcd_fmt_pkg::t_cfg   regs;
    mlcd_fmt_pkg::t_state lcd;
    mlcd_fmt_pkg::t_res   spi_due[$];
    mlcd_fmt_pkg::t_res   want;
    mlcd_fmt_pkg::t_res   got;
    int unsigned          fails;
    int unsigned          checked;

    initial begin
        fails     = 0;
        checked   = 0;
        o_fails   = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic void push_res(input logic [7:0] b, input logic fend,
                                     input logic last, input logic err);
        mlcd_fmt_pkg::t_res r;
        r.spi_byte  = b;
        r.frame_end = fend;
        r.run_last  = last;
        r.error     = err;
        spi_due.push_back(r);
    endfunction

    // line address goes out LSB first
    function automatic logic [7:0] flip_bits(input logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) r[b] = v[7 - b];
        return r;
    endfunction

    function automatic logic [7:0] toggle_vcom();
        lcd.vcom_phase = ~lcd.vcom_phase;
        return lcd.vcom_phase ? regs.vcom_mask : 8'h00;
    endfunction

    // expected SPI bytes for one accepted item; rejects leave state alone
    function automatic void format_op(input logic [2:0] op, input logic [7:0] line,
                                      input logic [7:0] pix);
        logic [7:0] cmd;
        case (op)
            mlcd_fmt_pkg::OP_CLEAR, mlcd_fmt_pkg::OP_REFRESH: begin
                if (lcd.updating) begin
                    push_res(8'h00, 1'b0, 1'b1, 1'b1);
                end else begin
                    cmd = toggle_vcom();
                    if (op == mlcd_fmt_pkg::OP_CLEAR) cmd = cmd | regs.clear_mask;
                    push_res(cmd, 1'b0, 1'b0, 1'b0);
                    push_res(8'h00, 1'b1, 1'b1, 1'b0);
                end
            end
            mlcd_fmt_pkg::OP_HEADER: begin
                if (line == 8'h00) begin
                    push_res(8'h00, 1'b0, 1'b1, 1'b1);
                end else begin
                    if (!lcd.updating) begin
                        cmd = toggle_vcom() | regs.write_mask;
                        lcd.updating = 1'b1;
                    end else begin
                        cmd = 8'h00;
                    end
                    lcd.line_open     = 1'b1;
                    lcd.bytes_in_line = 8'h00;
                    push_res(cmd, 1'b0, 1'b0, 1'b0);
                    push_res(flip_bits(line), 1'b0, 1'b1, 1'b0);
                end
            end
            mlcd_fmt_pkg::OP_DATA: begin
                if (!lcd.updating || !lcd.line_open ||
                    lcd.bytes_in_line >= regs.line_bytes) begin
                    push_res(8'h00, 1'b0, 1'b1, 1'b1);
                end else begin
                    lcd.bytes_in_line = lcd.bytes_in_line + 8'd1;
                    push_res(pix, 1'b0, 1'b1, 1'b0);
                end
            end
            mlcd_fmt_pkg::OP_FINISH: begin
                if (!lcd.updating) begin
                    push_res(8'h00, 1'b0, 1'b1, 1'b1);
                end else begin
                    lcd.updating      = 1'b0;
                    lcd.line_open     = 1'b0;
                    lcd.bytes_in_line = 8'h00;
                    push_res(8'h00, 1'b0, 1'b0, 1'b0);
                    push_res(8'h00, 1'b1, 1'b1, 1'b0);
                end
            end
            default: push_res(8'h00, 1'b0, 1'b1, 1'b1);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.vcom_mask  = mlcd_fmt_pkg::RST_VCOM_MASK;
            regs.clear_mask = mlcd_fmt_pkg::RST_CLEAR_MASK;
            regs.write_mask = mlcd_fmt_pkg::RST_WRITE_MASK;
            regs.line_bytes = mlcd_fmt_pkg::RST_LINE_BYTES;
            lcd             = '0;
            spi_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mlcd_fmt_pkg::REG_VCOM_MASK:  regs.vcom_mask  = i_cfg_data;
                    mlcd_fmt_pkg::REG_CLEAR_MASK: regs.clear_mask = i_cfg_data;
                    mlcd_fmt_pkg::REG_WRITE_MASK: regs.write_mask = i_cfg_data;
                    mlcd_fmt_pkg::REG_LINE_BYTES: regs.line_bytes = i_cfg_data;
                    default: ;
                endcase
            end
            // results first: an item accepted now cannot have produced one yet
            if (i_m_tvalid && i_m_tready) begin
                got.spi_byte  = i_m_tdata;
                got.frame_end = i_m_tlast;
                got.run_last  = i_m_tuser[0];
                got.error     = i_m_tuser[1];
                if (spi_due.size() == 0) begin
                    $error("unexpected result: spi_byte %h frame_end %b run_last %b error %b",
                           got.spi_byte, got.frame_end, got.run_last, got.error);
                    fails++;
                end else begin
                    want = spi_due.pop_front();
                    checked++;
                    if (got.spi_byte !== want.spi_byte) begin
                        $error("spi_byte: expected %h, got %h", want.spi_byte, got.spi_byte);
                        fails++;
                    end
                    if (got.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %b, got %b",
                               want.frame_end, got.frame_end);
                        fails++;
                    end
                    if (got.run_last !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                        fails++;
                    end
                    if (got.error !== want.error) begin
                        $error("error: expected %b, got %b", want.error, got.error);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                format_op(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8]);
        end
        o_fails   <= fails;
        o_pending <= spi_due.size();
        o_checked <= checked;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: drives display operations and register writes, reports the verdict.
`timescale 1ns / 1ps

module tb_top;

    // op codes the block has no meaning for; all must be rejected
    localparam logic [2:0] OP_UNDEF_A = 3'd5;
    localparam logic [2:0] OP_UNDEF_B = 3'd6;
    localparam logic [2:0] OP_UNDEF_C = 3'd7;

    // worst case is roughly 2 bytes per item, each behind a long stall
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned PHASE_ITEMS   = 250;
    localparam int unsigned RANDOM_PHASES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;      // [7:0] line_number, [15:8] pixel_byte
    logic [2:0]  s_axis_tuser;      // [2:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;      // [7:0] spi_byte
    logic        m_axis_tlast;      // frame_end
    logic [1:0]  m_axis_tuser;      // [0] run_last, [1] error
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;

    int unsigned fails;
    int unsigned pending;
    int unsigned checked;

    // sender bookkeeping
    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned settings_used;
    logic [7:0]  cur_line_bytes;

    // receiver stall pattern
    int unsigned cycle_count;
    int unsigned mode_left;
    int unsigned ready_mode;

    memory_lcd_spi_frame_formatter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    mlcd_stream_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tlast  (m_axis_tlast),
        .i_m_tuser  (m_axis_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_fails    (fails),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog plus the receiver's stall pattern. The pattern switches among
    // always ready, light random stalls, a fixed 1-in-4 stall and heavy
    // random stalls, each for a random stretch of cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("simulation failed");
            $finish;
        end
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 200);
        end
        mode_left = mode_left - 1;
        case (ready_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= (cycle_count[1:0] != 2'b00);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // One item on s_axis. Called at a clock edge; returns at the edge where it
    // is accepted, with tvalid still high so back-to-back items stay valid.
    task automatic send_item(input logic [2:0] op, input logic [7:0] line,
                             input logic [7:0] pix);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pix, line};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left = burst_left - 1;
        items_sent = items_sent + 1;
    endtask

    // Drop tvalid and wait until every predicted byte has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // All four registers, back to back; only called with the block idle.
    task automatic set_regs(input logic [7:0] vcom, input logic [7:0] clr,
                            input logic [7:0] wr, input logic [7:0] lb);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= mlcd_fmt_pkg::REG_VCOM_MASK;
        i_cfg_data <= vcom;
        @(posedge i_clk);
        i_cfg_idx  <= mlcd_fmt_pkg::REG_CLEAR_MASK;
        i_cfg_data <= clr;
        @(posedge i_clk);
        i_cfg_idx  <= mlcd_fmt_pkg::REG_WRITE_MASK;
        i_cfg_data <= wr;
        @(posedge i_clk);
        i_cfg_idx  <= mlcd_fmt_pkg::REG_LINE_BYTES;
        i_cfg_data <= lb;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        cur_line_bytes  = lb;
        settings_used   = settings_used + 1;
    endtask

    // Mostly well-formed update with random content: one to four lines, each with a
    // random byte count, now and then one byte too many or no finish at all.
    task automatic random_update();
        int unsigned n_lines;
        int unsigned n_data;
        n_lines = $urandom_range(1, 4);
        repeat (n_lines) begin
            send_item(mlcd_fmt_pkg::OP_HEADER, 8'($urandom_range(1, 255)),
                      8'($urandom_range(0, 255)));
            if (cur_line_bytes > 16 && $urandom_range(0, 15) != 0)
                n_data = $urandom_range(0, 12);
            else
                n_data = $urandom_range(0, cur_line_bytes);
            if ($urandom_range(0, 7) == 0)
                n_data = cur_line_bytes + 1;
            repeat (n_data)
                send_item(mlcd_fmt_pkg::OP_DATA, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) != 0)
            send_item(mlcd_fmt_pkg::OP_FINISH, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
    endtask

    initial begin
        int unsigned phase_start;
        int unsigned pick;

        items_sent    = 0;
        burst_left    = 0;
        settings_used = 1;
        cycle_count   = 0;
        mode_left     = 0;
        ready_mode    = 0;
        cur_line_bytes = mlcd_fmt_pkg::RST_LINE_BYTES;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mlcd_fmt_pkg::OP_CLEAR;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= mlcd_fmt_pkg::REG_VCOM_MASK;
        i_cfg_data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset values: illegal ops outside an update,
        // plain clear and refresh, then one update with misuses inside.
        send_item(mlcd_fmt_pkg::OP_DATA,    8'h00, 8'hff);   // data with no header
        send_item(mlcd_fmt_pkg::OP_FINISH,  8'hff, 8'h00);   // finish with no update
        send_item(OP_UNDEF_A, 8'hff, 8'hff);
        send_item(OP_UNDEF_B, 8'h00, 8'h00);
        send_item(OP_UNDEF_C, 8'h55, 8'haa);
        send_item(mlcd_fmt_pkg::OP_CLEAR,   8'h00, 8'h00);
        send_item(mlcd_fmt_pkg::OP_REFRESH, 8'hff, 8'hff);
        send_item(mlcd_fmt_pkg::OP_HEADER,  8'h00, 8'hff);   // line zero, no update open
        send_item(mlcd_fmt_pkg::OP_HEADER,  8'h01, 8'hff);   // first header opens update
        send_item(mlcd_fmt_pkg::OP_DATA,    8'hff, 8'h00);
        send_item(mlcd_fmt_pkg::OP_DATA,    8'h00, 8'hff);
        send_item(mlcd_fmt_pkg::OP_HEADER,  8'h00, 8'h00);   // line zero inside an update
        send_item(mlcd_fmt_pkg::OP_CLEAR,   8'h01, 8'h00);   // commands inside an update
        send_item(mlcd_fmt_pkg::OP_REFRESH, 8'h01, 8'h00);
        send_item(mlcd_fmt_pkg::OP_HEADER,  8'hff, 8'h00);   // later header, short line
        send_item(mlcd_fmt_pkg::OP_HEADER,  8'h80, 8'h00);
        send_item(mlcd_fmt_pkg::OP_DATA,    8'h00, 8'h5a);
        send_item(mlcd_fmt_pkg::OP_FINISH,  8'h00, 8'h00);
        drain();

        // One-byte lines: the second byte overruns.
        set_regs(8'hff, 8'h00, 8'hff, 8'd1);
        send_item(mlcd_fmt_pkg::OP_HEADER,  8'h01, 8'h00);
        send_item(mlcd_fmt_pkg::OP_DATA,    8'h00, 8'h3c);
        send_item(mlcd_fmt_pkg::OP_DATA,    8'h00, 8'hc3);
        send_item(mlcd_fmt_pkg::OP_FINISH,  8'h00, 8'h00);
        send_item(mlcd_fmt_pkg::OP_REFRESH, 8'h00, 8'h00);
        drain();

        // Zero-length lines: every data byte is rejected.
        set_regs(8'h00, 8'hff, 8'h00, 8'd0);
        send_item(mlcd_fmt_pkg::OP_HEADER,  8'h7e, 8'h00);
        send_item(mlcd_fmt_pkg::OP_DATA,    8'h00, 8'h81);
        send_item(mlcd_fmt_pkg::OP_FINISH,  8'h00, 8'h00);
        send_item(mlcd_fmt_pkg::OP_CLEAR,   8'h00, 8'h00);
        drain();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_regs(mlcd_fmt_pkg::RST_VCOM_MASK, mlcd_fmt_pkg::RST_CLEAR_MASK,
                            mlcd_fmt_pkg::RST_WRITE_MASK, mlcd_fmt_pkg::RST_LINE_BYTES);
                1: set_regs(8'hff, 8'hff, 8'hff, 8'd255);
                2: set_regs(8'h01, 8'h80, 8'h02, 8'd2);
                default: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)),
                                  8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                                 : $urandom_range(1, 8)));
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    // noise: any op code, any fields
                    send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                else if (pick < 30)
                    send_item(($urandom_range(0, 1) != 0) ? mlcd_fmt_pkg::OP_CLEAR
                                                          : mlcd_fmt_pkg::OP_REFRESH,
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else
                    random_update();
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        $display("covered %0d items under %0d register settings, %0d results checked",
                 items_sent, settings_used, checked);
        $display("incl. undefined ops, line zero, overruns, commands inside updates");
        if (fails == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
